### src/bmhq_pkg.sv
// Package for the binary min-heap queue: payload structs, action and status codes,
// and controller state encoding. No dependencies.
`timescale 1ns / 1ps
package bmhq_pkg;
  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_EXTRACT = 2'd1,
    ACT_DECR    = 2'd2,
    ACT_DELETE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_RANGE   = 3'd3,
    ST_NOT_DEC = 3'd4
  } status_e;

  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] key_value;
    logic [5:0]         slot_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] removed_value;
    logic signed [31:0] current_min;
    logic [6:0]         entry_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_SLOT,    // read target slot (decrease/delete) or last (extract)
    S_RD_LAST,    // delete: read last entry
    S_CHK,        // classify move direction for delete
    S_UP_RD,      // sift-up: read parent
    S_UP_CMP,     // sift-up: compare and swap
    S_DN_RDL,     // sift-down: read left child
    S_DN_RDR,     // sift-down: read right child
    S_DN_CMP,     // sift-down: pick smallest and swap
    S_RD_ROOT,    // refresh root copy
    S_ROOT_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               we;
    logic [11:0]        waddr;
    logic signed [31:0] wdata;
    logic [11:0]        raddr;
  } mem_req_t;
endpackage

### src/bmhq_store.sv
// Heap key store: one-write, one-read synchronous RAM with registered read data.
// Depends on bmhq_pkg for the request struct.
`timescale 1ns / 1ps
module bmhq_store #(
  parameter int CAPACITY = 64,
  parameter int AW = 6
) (
  input  logic                clk_i,
  input  bmhq_pkg::mem_req_t  req_i,
  output logic signed [31:0]  rdata_o
);
  logic signed [31:0] mem_q [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr[AW-1:0]];
  end
endmodule

### src/binary_min_heap_queue.sv
// Binary min-heap priority queue: one transaction in, one result out.
// Keys sit in a single synchronous RAM (bmhq_store); a sequencer reads,
// compares and writes back one heap level at a time. Sift-up reads the parent and
// then compares and swaps; sift-down reads the left child, reads the right child,
// then compares and swaps. The input stalls while an action is in progress, including
// while its finished result waits behind a stalled output. Depends on bmhq_pkg and bmhq_store.
`timescale 1ns / 1ps
module binary_min_heap_queue #(
  parameter int CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bmhq_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bmhq_pkg::out_item_t out_data_o
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = (CW > 6) ? CW : 6;

  bmhq_pkg::state_e state_q, state_d;
  bmhq_pkg::mem_req_t req;
  logic signed [31:0] rdata;

  logic [CW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]      pos_q, pos_d;      // current slot of the moving key
  logic [AW-1:0]      sel_q, sel_d;      // left child slot in sift-down
  logic signed [31:0] key_q, key_d;      // moving key
  logic signed [31:0] best_q, best_d;    // left child key
  logic signed [31:0] root_q, root_d;
  logic [1:0]         act_q, act_d;
  logic [2:0]         st_q, st_d;
  logic signed [31:0] rem_q, rem_d;
  logic               ov_q, ov_d;
  bmhq_pkg::out_item_t out_q, out_d;

  logic [AW:0]        lchild, rchild;
  logic [AW-1:0]      parent;
  logic               accept;
  logic               slot_oor;
  logic               right_wins;
  logic signed [31:0] dn_min;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != bmhq_pkg::S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o = out_q;

  assign lchild = {pos_q, 1'b1};
  assign rchild = {pos_q, 1'b0} + {{AW{1'b0}}, 1'b1} + {{AW{1'b0}}, 1'b1};
  assign parent = (pos_q - {{(AW-1){1'b0}}, 1'b1}) >> 1;

  assign slot_oor   = SW'(in_data_i.slot_index) >= SW'(cnt_q);
  assign right_wins = (rchild < (AW+1)'(cnt_q)) && (rdata < best_q);
  assign dn_min     = right_wins ? rdata : best_q;

  bmhq_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
    .clk_i  (clk_i),
    .req_i  (req),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmhq_pkg::S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    sel_q  <= sel_d;
    key_q  <= key_d;
    best_q <= best_d;
    root_q <= root_d;
    act_q  <= act_d;
    st_q   <= st_d;
    rem_q  <= rem_d;
    out_q  <= out_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bmhq_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_data_i.action)
            bmhq_pkg::ACT_INSERT:
              state_d = (cnt_q == CW'(CAPACITY)) ? bmhq_pkg::S_DONE : bmhq_pkg::S_UP_RD;
            bmhq_pkg::ACT_EXTRACT:
              state_d = (cnt_q == '0) ? bmhq_pkg::S_DONE : bmhq_pkg::S_RD_SLOT;
            default:
              state_d = slot_oor ? bmhq_pkg::S_DONE : bmhq_pkg::S_RD_SLOT;
          endcase
        end
      end
      bmhq_pkg::S_RD_SLOT: begin
        unique case (act_q)
          bmhq_pkg::ACT_EXTRACT:
            state_d = (cnt_q == '0) ? bmhq_pkg::S_DONE : bmhq_pkg::S_DN_RDL;
          bmhq_pkg::ACT_DECR:
            state_d = (rdata < key_q) ? bmhq_pkg::S_DONE : bmhq_pkg::S_UP_RD;
          default:
            state_d = (CW'(pos_q) == cnt_q) ? bmhq_pkg::S_RD_ROOT
                                             : bmhq_pkg::S_RD_LAST;
        endcase
      end
      bmhq_pkg::S_RD_LAST: state_d = bmhq_pkg::S_CHK;
      bmhq_pkg::S_CHK:
        state_d = (pos_q != '0 && key_q < rdata) ? bmhq_pkg::S_UP_RD : bmhq_pkg::S_DN_RDL;
      bmhq_pkg::S_UP_RD:
        state_d = (pos_q == '0) ? bmhq_pkg::S_RD_ROOT : bmhq_pkg::S_UP_CMP;
      bmhq_pkg::S_UP_CMP:
        state_d = (key_q < rdata) ? bmhq_pkg::S_UP_RD : bmhq_pkg::S_RD_ROOT;
      bmhq_pkg::S_DN_RDL:
        state_d = (lchild >= (AW+1)'(cnt_q)) ? bmhq_pkg::S_RD_ROOT : bmhq_pkg::S_DN_RDR;
      bmhq_pkg::S_DN_RDR: state_d = bmhq_pkg::S_DN_CMP;
      bmhq_pkg::S_DN_CMP:
        state_d = (dn_min < key_q) ? bmhq_pkg::S_DN_RDL : bmhq_pkg::S_RD_ROOT;
      bmhq_pkg::S_RD_ROOT:   state_d = bmhq_pkg::S_ROOT_WAIT;
      bmhq_pkg::S_ROOT_WAIT: state_d = bmhq_pkg::S_DONE;
      bmhq_pkg::S_DONE:
        state_d = (ov_q && out_stall_i) ? bmhq_pkg::S_DONE : bmhq_pkg::S_IDLE;
      default: state_d = bmhq_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req    = '0;
    cnt_d  = cnt_q;
    pos_d  = pos_q;
    sel_d  = sel_q;
    key_d  = key_q;
    best_d = best_q;
    root_d = root_q;
    act_d  = act_q;
    st_d   = st_q;
    rem_d  = rem_q;
    ov_d   = ov_q && out_stall_i;
    out_d  = out_q;
    unique case (state_q)
      bmhq_pkg::S_IDLE: begin
        if (accept) begin
          act_d = in_data_i.action;
          key_d = in_data_i.key_value;
          pos_d = AW'(in_data_i.slot_index);
          st_d  = bmhq_pkg::ST_OK;
          rem_d = '0;
          unique case (in_data_i.action)
            bmhq_pkg::ACT_INSERT: begin
              if (cnt_q == CW'(CAPACITY)) begin
                st_d = bmhq_pkg::ST_FULL;
              end else begin
                pos_d = cnt_q[AW-1:0];
                cnt_d = cnt_q + CW'(1);
              end
            end
            bmhq_pkg::ACT_EXTRACT: begin
              if (cnt_q == '0) begin
                st_d  = bmhq_pkg::ST_EMPTY;
                rem_d = bmhq_pkg::KEY_MAX;
              end else begin
                rem_d = root_q;
                cnt_d = cnt_q - CW'(1);
                pos_d = '0;
                req.raddr = 12'(cnt_q - CW'(1));
              end
            end
            default: begin
              if (slot_oor) begin
                st_d = bmhq_pkg::ST_RANGE;
              end else begin
                req.raddr = 12'(in_data_i.slot_index);
                if (in_data_i.action == bmhq_pkg::ACT_DELETE) cnt_d = cnt_q - CW'(1);
              end
            end
          endcase
        end
      end
      bmhq_pkg::S_RD_SLOT: begin
        unique case (act_q)
          bmhq_pkg::ACT_EXTRACT: begin
            key_d = rdata;
            if (cnt_q != '0) begin
              req.we = 1'b1; req.waddr = '0; req.wdata = rdata;
            end
          end
          bmhq_pkg::ACT_DECR: begin
            if (rdata < key_q) st_d = bmhq_pkg::ST_NOT_DEC;
            else begin
              req.we = 1'b1; req.waddr = 12'(pos_q); req.wdata = key_q;
            end
          end
          default: begin
            rem_d = rdata;
            req.raddr = 12'(cnt_q);
          end
        endcase
      end
      bmhq_pkg::S_RD_LAST: begin
        key_d = rdata;
        req.we = 1'b1; req.waddr = 12'(pos_q); req.wdata = rdata;
        req.raddr = 12'(parent);
      end
      bmhq_pkg::S_CHK: begin
        // a larger parent moves down and the key starts sifting up
        if (pos_q != '0 && key_q < rdata) begin
          req.we = 1'b1; req.waddr = 12'(pos_q); req.wdata = rdata;
          pos_d = parent;
          act_d = bmhq_pkg::ACT_INSERT;
        end
      end
      bmhq_pkg::S_UP_RD: begin
        req.raddr = 12'(parent);
        if (act_q == bmhq_pkg::ACT_INSERT || pos_q == '0) begin
          req.we = 1'b1; req.waddr = 12'(pos_q); req.wdata = key_q;
        end
      end
      bmhq_pkg::S_UP_CMP: begin
        req.we = 1'b1; req.waddr = 12'(pos_q);
        if (key_q < rdata) begin
          req.wdata = rdata;
          pos_d = parent;
          // S_UP_RD then writes the key one level up; a later swap overwrites it
          act_d = bmhq_pkg::ACT_INSERT;
        end else begin
          req.wdata = key_q;
        end
      end
      bmhq_pkg::S_DN_RDL: begin
        req.raddr = 12'(lchild);
        sel_d = lchild[AW-1:0];
        if (lchild >= (AW+1)'(cnt_q)) begin
          req.we = 1'b1; req.waddr = 12'(pos_q); req.wdata = key_q;
        end
      end
      bmhq_pkg::S_DN_RDR: begin
        best_d = rdata;
        req.raddr = 12'(rchild);
      end
      bmhq_pkg::S_DN_CMP: begin
        req.we = 1'b1; req.waddr = 12'(pos_q);
        if (dn_min < key_q) begin
          req.wdata = dn_min;
          pos_d = right_wins ? rchild[AW-1:0] : sel_q;
        end else begin
          req.wdata = key_q;
        end
      end
      bmhq_pkg::S_RD_ROOT: req.raddr = '0;
      bmhq_pkg::S_ROOT_WAIT: root_d = rdata;
      bmhq_pkg::S_DONE: begin
        if (!(ov_q && out_stall_i)) begin
          ov_d = 1'b1;
          out_d.status        = st_q;
          out_d.removed_value = rem_q;
          out_d.current_min   = (cnt_q == '0) ? 32'sd0 : root_q;
          out_d.entry_count   = 7'(cnt_q);
        end
      end
      default: ;
    endcase
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY)) else $error("count exceeds capacity");
  a_one_per_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != bmhq_pkg::S_IDLE) else $error("accepted item lost");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");
endmodule
